// ===== sv/tcn_pkg.sv =====
// Shared types, byte codes and tables of the telnet client negotiator.
`default_nettype none
package tcn_pkg;

   localparam int TERM_BYTES_DEF = 8;
   localparam int QUEUE_DEPTH    = 4;
   localparam int POS_W          = 5;

   // telnet command and option bytes
   localparam logic [7:0] B_IAC      = 8'd255;
   localparam logic [7:0] B_DONT     = 8'd254;
   localparam logic [7:0] B_DO       = 8'd253;
   localparam logic [7:0] B_WONT     = 8'd252;
   localparam logic [7:0] B_WILL     = 8'd251;
   localparam logic [7:0] B_SB       = 8'd250;
   localparam logic [7:0] B_SE       = 8'd240;
   localparam logic [7:0] OPT_BINARY = 8'd0;
   localparam logic [7:0] OPT_ECHO   = 8'd1;
   localparam logic [7:0] OPT_SGA    = 8'd3;
   localparam logic [7:0] OPT_TTYPE  = 8'd24;
   localparam logic [7:0] OPT_NAWS   = 8'd31;
   localparam logic [7:0] OPT_TSPEED = 8'd32;
   localparam logic [7:0] SUB_SEND   = 8'd1;
   localparam logic [7:0] SUB_IS     = 8'd0;

   localparam logic [1:0] FUNC_NET   = 2'd0;
   localparam logic [1:0] FUNC_APP   = 2'd1;
   localparam logic [1:0] FUNC_START = 2'd2;

   localparam logic [1:0] CSR_TERM_CHARS = 2'd0;
   localparam logic [1:0] CSR_TERM_LEN   = 2'd1;
   localparam logic [1:0] CSR_COLS       = 2'd2;
   localparam logic [1:0] CSR_ROWS       = 2'd3;

   localparam logic DEST_NET = 1'b0;
   localparam logic DEST_APP = 1'b1;

   typedef enum logic [3:0] {
      PS_DATA     = 4'd0,
      PS_IAC      = 4'd1,
      PS_DONT     = 4'd2,
      PS_SB       = 4'd3,
      PS_WILL     = 4'd4,
      PS_WONT     = 4'd5,
      PS_DO       = 4'd6,
      PS_SBOPT    = 4'd7,
      PS_SEND     = 4'd8,
      PS_SEND_IAC = 4'd9
   } tcn_pstate_type;

   // what the back end has to emit after the echo-out bytes
   typedef enum logic [2:0] {
      K_NONE,
      K_DATA,
      K_REPLY,
      K_NAWS,
      K_TTYPE,
      K_TSPEED,
      K_START
   } tcn_kind_type;

   typedef struct packed {
      tcn_kind_type   kind;
      logic [1:0]     pre_cnt;    // network copies of an application byte
      logic [7:0]     data;
      logic [7:0]     verb;
      logic           pre_echo;
      logic           pre_bin;
      tcn_pstate_type pre_state;
      logic           post_echo;
      logic           post_bin;
      tcn_pstate_type post_state;
   } tcn_job_type;

   function automatic logic [7:0] speed_char(input logic [3:0] idx);
      logic [7:0] ch;
      unique case (idx)
         4'd0, 4'd6:  ch = 8'h31;
         4'd1, 4'd7:  ch = 8'h39;
         4'd2, 4'd8:  ch = 8'h32;
         4'd5:        ch = 8'h2C;
         default:     ch = 8'h30;
      endcase
      return ch;
   endfunction

endpackage
`default_nettype wire

// ===== sv/tcn_if.sv =====
// Valid/ready channel interfaces for requests and responses.
`default_nettype none
interface tcn_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] func;
   logic [7:0] in_byte;

   modport source (output valid, func, in_byte, input ready);
   modport sink (input valid, func, in_byte, output ready);
endinterface

interface tcn_rsp_if;
   logic       valid;
   logic       ready;
   logic       dest;
   logic [7:0] out_byte;
   logic       last;
   logic       echo_on;
   logic       binary_on;
   logic [3:0] parse_state;

   modport source (output valid, dest, out_byte, last, echo_on, binary_on, parse_state,
                   input ready);
   modport sink (input valid, dest, out_byte, last, echo_on, binary_on, parse_state,
                 output ready);
endinterface
`default_nettype wire

// ===== sv/tcn_front.sv =====
// Front end: takes one byte per cycle while the job queue has room, runs the IAC parser and queues reply jobs.
`default_nettype none
module tcn_front import tcn_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   tcn_req_if.sink      req_chan,
   input  wire logic    queue_full,
   output tcn_job_type  push_job,
   output logic         push
);

   tcn_pstate_type state_ff, state_in;
   logic [7:0]     sub_ff, sub_in;
   logic           echo_ff, echo_in;
   logic           bin_ff, bin_in;
   logic           accept;
   logic           do_parse;
   logic [7:0]     c;
   tcn_kind_type   kind;
   logic [7:0]     verb;
   logic [1:0]     pre_cnt;

   assign req_chan.ready = !queue_full;
   assign accept         = req_chan.valid && !queue_full;
   assign c              = req_chan.in_byte;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= PS_DATA;
         sub_ff   <= 8'd0;
         echo_ff  <= 1'b1;
         bin_ff   <= 1'b0;
      end else if (accept) begin
         state_ff <= state_in;
         sub_ff   <= sub_in;
         echo_ff  <= echo_in;
         bin_ff   <= bin_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      sub_in   = sub_ff;
      echo_in  = echo_ff;
      bin_in   = bin_ff;
      kind     = K_NONE;
      verb     = B_WONT;
      pre_cnt  = 2'd0;
      do_parse = 1'b0;

      unique case (req_chan.func)
         FUNC_NET: do_parse = (c != 8'd0);
         FUNC_APP: begin
            pre_cnt  = (c == B_IAC) ? 2'd2 : 2'd1;
            do_parse = echo_ff;
         end
         FUNC_START: kind = K_START;
         default: ;
      endcase

      if (do_parse) begin
         unique case (state_ff)
            PS_DATA: begin
               if (c == B_IAC) state_in = PS_IAC;
               else kind = K_DATA;
            end
            PS_IAC: begin
               priority case (c)
                  B_IAC: begin
                     state_in = PS_DATA;
                     kind     = K_DATA;
                  end
                  B_WILL:  state_in = PS_WILL;
                  B_WONT:  state_in = PS_WONT;
                  B_DO:    state_in = PS_DO;
                  B_DONT:  state_in = PS_DONT;
                  B_SB:    state_in = PS_SB;
                  default: state_in = PS_DATA;
               endcase
            end
            PS_DO: begin
               state_in = PS_DATA;
               kind     = (c == OPT_NAWS) ? K_NAWS : K_REPLY;
               verb     = B_WONT;
               if (c == OPT_BINARY) begin
                  bin_in = 1'b1;
                  verb   = B_WILL;
               end else if (c == OPT_ECHO) begin
                  echo_in = 1'b1;
                  verb    = B_WILL;
               end else if (c == OPT_TTYPE || c == OPT_NAWS || c == OPT_TSPEED) begin
                  verb = B_WILL;
               end
            end
            PS_WILL: begin
               state_in = PS_DATA;
               kind     = K_REPLY;
               verb     = B_DONT;
               if (c == OPT_ECHO) begin
                  echo_in = 1'b0;
                  verb    = B_DO;
               end else if (c == OPT_SGA) begin
                  verb = B_DO;
               end else if (c == OPT_BINARY) begin
                  bin_in = 1'b1;
                  verb   = B_DO;
               end
            end
            PS_DONT: begin
               if (c == OPT_ECHO) echo_in = 1'b0;
               state_in = PS_DATA;
               kind     = K_REPLY;
               verb     = B_WONT;
            end
            PS_WONT: begin
               if (c == OPT_BINARY) bin_in = 1'b0;
               else if (c == OPT_ECHO) echo_in = 1'b1;
               state_in = PS_DATA;
               kind     = K_REPLY;
               verb     = B_DONT;
            end
            PS_SB: begin
               sub_in   = c;
               state_in = PS_SBOPT;
            end
            PS_SBOPT: state_in = (c == SUB_SEND) ? PS_SEND : PS_DATA;
            PS_SEND:  state_in = (c == B_IAC) ? PS_SEND_IAC : PS_DATA;
            PS_SEND_IAC: begin
               // any byte closes the subnegotiation
               state_in = PS_DATA;
               if (sub_ff == OPT_TTYPE) kind = K_TTYPE;
               else if (sub_ff == OPT_TSPEED) kind = K_TSPEED;
            end
            default: state_in = PS_DATA;
         endcase
      end

      push_job.kind       = kind;
      push_job.pre_cnt    = pre_cnt;
      push_job.data       = c;
      push_job.verb       = verb;
      push_job.pre_echo   = echo_ff;
      push_job.pre_bin    = bin_ff;
      push_job.pre_state  = state_ff;
      push_job.post_echo  = echo_in;
      push_job.post_bin   = bin_in;
      push_job.post_state = state_in;
      push = accept && (pre_cnt != 2'd0 || kind != K_NONE);
   end

endmodule
`default_nettype wire

// ===== sv/tcn_queue.sv =====
// Short job queue between the parser front end and the byte sequencer.
`default_nettype none
module tcn_queue import tcn_pkg::*; #(
   parameter int DEPTH = QUEUE_DEPTH
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         push,
   input  tcn_job_type       push_job,
   output logic              full,
   input  wire logic         pop,
   output logic              head_valid,
   output tcn_job_type       head_job
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   tcn_job_type   slot_ff [DEPTH];
   logic [AW-1:0] wr_ff, rd_ff;
   logic [CW-1:0] cnt_ff;

   function automatic logic [AW-1:0] bump(input logic [AW-1:0] p);
      return (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   assign full       = (cnt_ff == CW'(DEPTH));
   assign head_valid = (cnt_ff != '0);
   assign head_job   = slot_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (push) slot_ff[wr_ff] <= push_job;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (push) wr_ff <= bump(wr_ff);
         if (pop) rd_ff <= bump(rd_ff);
         if (push && !pop) cnt_ff <= cnt_ff + 1'b1;
         else if (pop && !push) cnt_ff <= cnt_ff - 1'b1;
      end
   end

endmodule
`default_nettype wire

// ===== sv/tcn_back.sv =====
// Back end: expands one queued job into response bytes, one per cycle while rsp_chan is ready.
`default_nettype none
module tcn_back import tcn_pkg::*; #(
   parameter int TERM_BYTES = TERM_BYTES_DEF
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    head_valid,
   input  tcn_job_type                  head_job,
   output logic                         pop,
   input  wire logic [8*TERM_BYTES-1:0] term_chars,
   input  wire logic [3:0]              term_len,
   input  wire logic [7:0]              window_cols,
   input  wire logic [7:0]              window_rows,
   tcn_rsp_if.source                    rsp_chan
);

   localparam int TW = (TERM_BYTES > 1) ? $clog2(TERM_BYTES) : 1;

   logic [POS_W-1:0] idx_ff;
   logic             valid_ff;
   logic             dest_ff, last_ff, echo_ff, bin_ff;
   logic [7:0]       byte_ff;
   logic [3:0]       pstate_ff;

   logic             adv, is_last, in_pre;
   logic [3:0]       n_term;
   logic [POS_W-1:0] len, kind_len, q, tq;
   logic [TW-1:0]    ti;
   logic             dest;
   logic [7:0]       ob;

   assign adv = head_valid && (!valid_ff || rsp_chan.ready);
   assign pop = adv && is_last;

   always_comb begin
      n_term = (term_len > 4'(TERM_BYTES)) ? 4'(TERM_BYTES) : term_len;
      unique case (head_job.kind)
         K_NONE:   kind_len = POS_W'(0);
         K_DATA:   kind_len = POS_W'(1);
         K_REPLY:  kind_len = POS_W'(3);
         K_NAWS:   kind_len = POS_W'(12);
         K_TTYPE:  kind_len = POS_W'(6) + POS_W'(n_term);
         K_TSPEED: kind_len = POS_W'(17);
         K_START:  kind_len = POS_W'(6);
         default:  kind_len = POS_W'(0);
      endcase
      len     = kind_len + POS_W'(head_job.pre_cnt);
      is_last = (idx_ff == len - 1'b1);
      in_pre  = (idx_ff < POS_W'(head_job.pre_cnt));
      q       = idx_ff - POS_W'(head_job.pre_cnt);
      tq      = q - POS_W'(4);
      ti      = tq[TW-1:0];
      dest    = DEST_NET;
      ob      = head_job.data;

      if (!in_pre) begin
         unique case (head_job.kind)
            K_DATA: dest = DEST_APP;
            K_REPLY, K_NAWS: begin
               unique case (q)
                  POS_W'(0), POS_W'(3), POS_W'(10): ob = B_IAC;
                  POS_W'(1):  ob = head_job.verb;
                  POS_W'(2):  ob = head_job.data;
                  POS_W'(4):  ob = B_SB;
                  POS_W'(5):  ob = OPT_NAWS;
                  POS_W'(7):  ob = window_cols;
                  POS_W'(9):  ob = window_rows;
                  POS_W'(11): ob = B_SE;
                  default:    ob = 8'd0;
               endcase
            end
            K_TTYPE, K_TSPEED: begin
               if (q == POS_W'(0)) ob = B_IAC;
               else if (q == POS_W'(1)) ob = B_SB;
               else if (q == POS_W'(2))
                  ob = (head_job.kind == K_TTYPE) ? OPT_TTYPE : OPT_TSPEED;
               else if (q == POS_W'(3)) ob = SUB_IS;
               else if (q == kind_len - POS_W'(2)) ob = B_IAC;
               else if (q == kind_len - POS_W'(1)) ob = B_SE;
               else if (head_job.kind == K_TTYPE) ob = term_chars[8*ti +: 8];
               else ob = speed_char(tq[3:0]);
            end
            K_START: begin
               unique case (q)
                  POS_W'(0), POS_W'(3): ob = B_IAC;
                  POS_W'(1), POS_W'(4): ob = B_WILL;
                  POS_W'(2):            ob = OPT_TTYPE;
                  default:              ob = OPT_NAWS;
               endcase
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         if (adv) begin
            idx_ff   <= is_last ? '0 : idx_ff + 1'b1;
            valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         dest_ff   <= dest;
         byte_ff   <= ob;
         last_ff   <= is_last;
         echo_ff   <= in_pre ? head_job.pre_echo : head_job.post_echo;
         bin_ff    <= in_pre ? head_job.pre_bin : head_job.post_bin;
         pstate_ff <= in_pre ? head_job.pre_state : head_job.post_state;
      end
   end

   assign rsp_chan.valid       = valid_ff;
   assign rsp_chan.dest        = dest_ff;
   assign rsp_chan.out_byte    = byte_ff;
   assign rsp_chan.last        = last_ff;
   assign rsp_chan.echo_on     = echo_ff;
   assign rsp_chan.binary_on   = bin_ff;
   assign rsp_chan.parse_state = pstate_ff;

endmodule
`default_nettype wire

// ===== sv/telnet_client_negotiator_core.sv =====
// Top level of the telnet client negotiator: config registers, parser, queue, sequencer.
//
//   channel    dir  handshake       payload
//   req_chan   in   valid/ready     func, in_byte
//   rsp_chan   out  valid/ready     dest, out_byte, last, echo_on, binary_on, parse_state
//   csr_*      in   csr_we          csr_index, csr_wdata
//
// The parser takes one byte per cycle while the job queue has room.
// The sequencer sends the response bytes of each item in order (1 to 19 per item);
// data bytes stream at 1/cycle while rsp_chan is ready.
// Reset is synchronous; after it the block accepts at once.
// A stalled rsp_chan fills the 4-entry job queue before req_chan stalls.
`default_nettype none
module telnet_client_negotiator_core import tcn_pkg::*; #(
   parameter int TERM_BYTES = TERM_BYTES_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   tcn_req_if.sink          req_chan,
   tcn_rsp_if.source        rsp_chan,
   input  wire logic        csr_we,
   input  wire logic [1:0]  csr_index,
   input  wire logic [63:0] csr_wdata
);

   logic [8*TERM_BYTES-1:0] term_chars_ff;
   logic [3:0]              term_len_ff;
   logic [7:0]              cols_ff, rows_ff;

   tcn_job_type push_job, head_job;
   logic        push, queue_full, pop, head_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         term_chars_ff <= '0;
         term_len_ff   <= 4'd0;
         cols_ff       <= 8'd80;
         rows_ff       <= 8'd24;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_TERM_CHARS: term_chars_ff <= csr_wdata[8*TERM_BYTES-1:0];
            CSR_TERM_LEN:   term_len_ff   <= csr_wdata[3:0];
            CSR_COLS:       cols_ff       <= csr_wdata[7:0];
            CSR_ROWS:       rows_ff       <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   tcn_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .queue_full (queue_full),
      .push_job   (push_job),
      .push       (push)
   );

   tcn_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_job   (push_job),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_job   (head_job)
   );

   tcn_back #(.TERM_BYTES(TERM_BYTES)) u_back (
      .clock       (clock),
      .reset       (reset),
      .head_valid  (head_valid),
      .head_job    (head_job),
      .pop         (pop),
      .term_chars  (term_chars_ff),
      .term_len    (term_len_ff),
      .window_cols (cols_ff),
      .window_rows (rows_ff),
      .rsp_chan    (rsp_chan)
   );

endmodule
`default_nettype wire

// ===== sv/tcn_checker.sv =====
// Port-level checks of the negotiator core, bound to the top level.
`default_nettype none
module tcn_checker import tcn_pkg::*; (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic       rsp_dest,
   input wire logic [7:0] rsp_out_byte,
   input wire logic       rsp_last,
   input wire logic [3:0] rsp_parse_state
);

   // a stalled transfer keeps its byte
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_byte) && $stable(rsp_last))
      else $error("response changed while stalled");

   a_reset_quiet: assert property (@(posedge clock)
      $fell(reset) |-> !rsp_valid)
      else $error("response valid right after reset");

   // bytes for the application always end their item and leave the parser in data
   a_app_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_dest |-> rsp_last && rsp_parse_state == PS_DATA)
      else $error("application byte not last or parser not in data");

   a_state_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_parse_state <= PS_SEND_IAC)
      else $error("parser state out of range");

endmodule

bind telnet_client_negotiator_core tcn_checker u_tcn_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_chan.valid),
   .rsp_ready       (rsp_chan.ready),
   .rsp_dest        (rsp_chan.dest),
   .rsp_out_byte    (rsp_chan.out_byte),
   .rsp_last        (rsp_chan.last),
   .rsp_parse_state (rsp_chan.parse_state)
);
`default_nettype wire

// ===== tb/sv/reply_scoreboard.sv =====
// Reply predictor and scoreboard for the telnet client negotiator.
module reply_scoreboard import tcn_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   tcn_req_if          req_chan,
   tcn_rsp_if          rsp_chan,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [63:0] csr_wdata,
   output int          mismatch_count,
   output int          replies_pending
);

   localparam int          MAX_REPLIES     = 19;
   localparam logic [87:0] LINE_SPEED_TEXT = "19200,19200";

   typedef struct packed {
      logic       dest;
      logic [7:0] data;
      logic       last;
      logic       echo;
      logic       bin;
      logic [3:0] pstate;
   } reply_byte_type;

   // register shadows
   logic [63:0] term_text;
   logic [3:0]  term_count;
   logic [7:0]  cols_cfg;
   logic [7:0]  rows_cfg;

   // negotiator state as predicted
   tcn_pstate_type parser_q;
   logic [7:0]     sub_opt;
   logic           echo_q;
   logic           bin_q;

   reply_byte_type item_replies[$];
   reply_byte_type expected_replies[$];
   reply_byte_type want;
   bit             ok;

   function automatic void add_reply(input logic dest, input logic [7:0] b);
      reply_byte_type r;
      if (item_replies.size() < MAX_REPLIES) begin
         r.dest   = dest;
         r.data   = b;
         r.last   = 1'b0;
         r.echo   = echo_q;
         r.bin    = bin_q;
         r.pstate = parser_q;
         item_replies.push_back(r);
      end
   endfunction

   function automatic void add_net3(input logic [7:0] a, input logic [7:0] b,
                                    input logic [7:0] c);
      add_reply(DEST_NET, a);
      add_reply(DEST_NET, b);
      add_reply(DEST_NET, c);
   endfunction

   // flags and parser state move before the reply bytes of an option go out
   function automatic void parse_net(input logic [7:0] c);
      logic [7:0] verb;
      int         n;
      case (parser_q)
         PS_DATA: begin
            if (c == B_IAC) parser_q = PS_IAC;
            else add_reply(DEST_APP, c);
         end
         PS_IAC: begin
            parser_q = PS_DATA;
            case (c)
               B_IAC:   add_reply(DEST_APP, c);
               B_WILL:  parser_q = PS_WILL;
               B_WONT:  parser_q = PS_WONT;
               B_DO:    parser_q = PS_DO;
               B_DONT:  parser_q = PS_DONT;
               B_SB:    parser_q = PS_SB;
               default: ;
            endcase
         end
         PS_DO: begin
            verb = B_WONT;
            if (c == OPT_BINARY) begin
               bin_q = 1'b1;
               verb  = B_WILL;
            end else if (c == OPT_ECHO) begin
               echo_q = 1'b1;
               verb   = B_WILL;
            end else if (c == OPT_TTYPE || c == OPT_NAWS || c == OPT_TSPEED) begin
               verb = B_WILL;
            end
            parser_q = PS_DATA;
            add_net3(B_IAC, verb, c);
            if (c == OPT_NAWS) begin
               add_net3(B_IAC, B_SB, OPT_NAWS);
               add_reply(DEST_NET, 8'd0);
               add_reply(DEST_NET, cols_cfg);
               add_reply(DEST_NET, 8'd0);
               add_reply(DEST_NET, rows_cfg);
               add_reply(DEST_NET, B_IAC);
               add_reply(DEST_NET, B_SE);
            end
         end
         PS_WILL: begin
            verb = B_DONT;
            if (c == OPT_ECHO) begin
               echo_q = 1'b0;
               verb   = B_DO;
            end else if (c == OPT_SGA) begin
               verb = B_DO;
            end else if (c == OPT_BINARY) begin
               bin_q = 1'b1;
               verb  = B_DO;
            end
            parser_q = PS_DATA;
            add_net3(B_IAC, verb, c);
         end
         PS_DONT: begin
            if (c == OPT_ECHO) echo_q = 1'b0;
            parser_q = PS_DATA;
            add_net3(B_IAC, B_WONT, c);
         end
         PS_WONT: begin
            if (c == OPT_BINARY) bin_q = 1'b0;
            else if (c == OPT_ECHO) echo_q = 1'b1;
            parser_q = PS_DATA;
            add_net3(B_IAC, B_DONT, c);
         end
         PS_SB: begin
            sub_opt  = c;
            parser_q = PS_SBOPT;
         end
         PS_SBOPT: parser_q = (c == SUB_SEND) ? PS_SEND : PS_DATA;
         PS_SEND:  parser_q = (c == B_IAC) ? PS_SEND_IAC : PS_DATA;
         PS_SEND_IAC: begin
            // any byte closes the subnegotiation, SE or not
            parser_q = PS_DATA;
            if (sub_opt == OPT_TTYPE) begin
               n = (term_count > TERM_BYTES_DEF) ? TERM_BYTES_DEF : int'(term_count);
               add_net3(B_IAC, B_SB, OPT_TTYPE);
               add_reply(DEST_NET, SUB_IS);
               for (int k = 0; k < n; k++)
                  add_reply(DEST_NET, term_text[8*k +: 8]);
               add_reply(DEST_NET, B_IAC);
               add_reply(DEST_NET, B_SE);
            end else if (sub_opt == OPT_TSPEED) begin
               add_net3(B_IAC, B_SB, OPT_TSPEED);
               add_reply(DEST_NET, SUB_IS);
               for (int k = 0; k < 11; k++)
                  add_reply(DEST_NET, LINE_SPEED_TEXT[8*(10-k) +: 8]);
               add_reply(DEST_NET, B_IAC);
               add_reply(DEST_NET, B_SE);
            end
         end
         default: parser_q = PS_DATA;
      endcase
   endfunction

   function automatic void predict_item(input logic [1:0] f, input logic [7:0] b);
      item_replies.delete();
      case (f)
         FUNC_NET: if (b != 8'd0) parse_net(b);
         FUNC_APP: begin
            add_reply(DEST_NET, b);
            if (b == B_IAC) add_reply(DEST_NET, B_IAC);
            if (echo_q) parse_net(b);
         end
         FUNC_START: begin
            add_net3(B_IAC, B_WILL, OPT_TTYPE);
            add_net3(B_IAC, B_WILL, OPT_NAWS);
         end
         default: ;
      endcase
      if (item_replies.size() > 0)
         item_replies[item_replies.size() - 1].last = 1'b1;
      foreach (item_replies[i]) expected_replies.push_back(item_replies[i]);
   endfunction

   function automatic bit field_ok(input string name, input logic [7:0] exp_val,
                                   input logic [7:0] act_val);
      if (exp_val !== act_val) begin
         $error("%s: expected %0d, got %0d", name, exp_val, act_val);
         return 1'b0;
      end
      return 1'b1;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         term_text      = '0;
         term_count     = '0;
         cols_cfg       = 8'd80;
         rows_cfg       = 8'd24;
         parser_q       = PS_DATA;
         sub_opt        = '0;
         echo_q         = 1'b1;
         bin_q          = 1'b0;
         mismatch_count = 0;
         expected_replies.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_TERM_CHARS: term_text  = csr_wdata;
               CSR_TERM_LEN:   term_count = csr_wdata[3:0];
               CSR_COLS:       cols_cfg   = csr_wdata[7:0];
               CSR_ROWS:       rows_cfg   = csr_wdata[7:0];
               default: ;
            endcase
         end
         // input side first so a same-cycle reply still finds its expectation
         if (req_chan.valid && req_chan.ready)
            predict_item(req_chan.func, req_chan.in_byte);
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (expected_replies.size() == 0) begin
               $error("out_byte: expected no transfer, got %0d", rsp_chan.out_byte);
               mismatch_count++;
            end else begin
               want = expected_replies.pop_front();
               ok = 1'b1;
               ok &= field_ok("dest", 8'(want.dest), 8'(rsp_chan.dest));
               ok &= field_ok("out_byte", want.data, rsp_chan.out_byte);
               ok &= field_ok("last", 8'(want.last), 8'(rsp_chan.last));
               ok &= field_ok("echo_on", 8'(want.echo), 8'(rsp_chan.echo_on));
               ok &= field_ok("binary_on", 8'(want.bin), 8'(rsp_chan.binary_on));
               ok &= field_ok("parse_state", 8'(want.pstate), 8'(rsp_chan.parse_state));
               if (!ok) mismatch_count++;
            end
         end
      end
      replies_pending = expected_replies.size();
   end

endmodule

// ===== tb/sv/tb.sv =====
// Stimulus, handshake pacing and verdict for the telnet client negotiator.
module tb;
   import tcn_pkg::*;

   localparam logic [1:0] FUNC_UNUSED   = 2'd3;
   localparam int         CYCLE_LIMIT   = 500000;
   localparam int         SETTLE_CYCLES = 25;
   localparam int         HOLD_CYCLES   = 300;
   localparam int         PHASE_ITEMS   = 34;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_we;
   logic [1:0]  csr_index;
   logic [63:0] csr_wdata;

   int tx_idle_pct;
   int rx_idle_pct;
   int hold_request;
   int hold_seen;
   int hold_left;
   int sent_items;
   int cycle_count;
   int mismatch_count;
   int replies_pending;

   tcn_req_if req_chan ();
   tcn_rsp_if rsp_chan ();

   telnet_client_negotiator_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   reply_scoreboard reply_check (
      .clock           (clock),
      .reset           (reset),
      .req_chan        (req_chan),
      .rsp_chan        (rsp_chan),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .mismatch_count  (mismatch_count),
      .replies_pending (replies_pending)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // receiver pacing; a hold request stalls the reply channel for a long stretch
   always @(negedge clock) begin
      if (hold_seen != hold_request) begin
         hold_seen = hold_request;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_chan.ready <= 1'b0;
      end else begin
         rsp_chan.ready <= ($urandom_range(99) >= rx_idle_pct);
      end
   end

   // called and returns at a falling edge
   task automatic send_item(input logic [1:0] f, input logic [7:0] b);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(negedge clock);
      end
      req_chan.valid   <= 1'b1;
      req_chan.func    <= f;
      req_chan.in_byte <= b;
      do @(posedge clock); while (!req_chan.ready);
      sent_items++;
      @(negedge clock);
   endtask

   task automatic program_regs(input logic [63:0] chars, input logic [3:0] len,
                               input logic [7:0] cols, input logic [7:0] rows);
      csr_we    <= 1'b1;
      csr_index <= CSR_TERM_CHARS;
      csr_wdata <= chars;
      @(negedge clock);
      csr_index <= CSR_TERM_LEN;
      csr_wdata <= {60'd0, len};
      @(negedge clock);
      csr_index <= CSR_COLS;
      csr_wdata <= {56'd0, cols};
      @(negedge clock);
      csr_index <= CSR_ROWS;
      csr_wdata <= {56'd0, rows};
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   // drain: all predicted replies seen, then room for items that emit nothing
   task automatic wait_idle();
      req_chan.valid <= 1'b0;
      while (replies_pending != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   function automatic logic [7:0] pick_option();
      case ($urandom_range(7))
         0:       return OPT_BINARY;
         1:       return OPT_ECHO;
         2:       return OPT_SGA;
         3:       return OPT_TTYPE;
         4:       return OPT_NAWS;
         5:       return OPT_TSPEED;
         default: return 8'($urandom_range(255));
      endcase
   endfunction

   task automatic send_random_sequence();
      int         kind;
      logic [7:0] opt;
      kind = $urandom_range(99);
      if (kind < 25) begin
         send_item(FUNC_NET, B_IAC);
         case ($urandom_range(3))
            0:       send_item(FUNC_NET, B_WILL);
            1:       send_item(FUNC_NET, B_WONT);
            2:       send_item(FUNC_NET, B_DO);
            default: send_item(FUNC_NET, B_DONT);
         endcase
         send_item(FUNC_NET, pick_option());
      end else if (kind < 45) begin
         // subnegotiation, now and then broken or closed by a stray byte
         opt = ($urandom_range(3) == 0) ? pick_option() :
               ($urandom_range(1) ? OPT_TTYPE : OPT_TSPEED);
         send_item(FUNC_NET, B_IAC);
         send_item(FUNC_NET, B_SB);
         send_item(FUNC_NET, opt);
         send_item(FUNC_NET, ($urandom_range(9) == 0) ? 8'($urandom_range(255)) : SUB_SEND);
         send_item(FUNC_NET, ($urandom_range(9) == 0) ? 8'($urandom_range(255)) : B_IAC);
         send_item(FUNC_NET, ($urandom_range(3) == 0) ? 8'($urandom_range(255)) : B_SE);
      end else if (kind < 60) begin
         repeat ($urandom_range(1, 6)) send_item(FUNC_NET, 8'($urandom_range(255)));
      end else if (kind < 75) begin
         repeat ($urandom_range(1, 4))
            send_item(FUNC_APP, ($urandom_range(7) == 0) ? B_IAC : 8'($urandom_range(255)));
      end else if (kind < 82) begin
         send_item(FUNC_NET, B_IAC);
         send_item(FUNC_NET, $urandom_range(1) ? B_IAC : 8'($urandom_range(1, 249)));
      end else if (kind < 88) begin
         send_item(FUNC_START, 8'($urandom_range(255)));
      end else if (kind < 93) begin
         send_item(FUNC_UNUSED, 8'($urandom_range(255)));
      end else begin
         send_item(FUNC_NET, 8'($urandom_range(255)));
      end
   endtask

   task automatic run_random_phase(input int count);
      int target;
      target = sent_items + count;
      while (sent_items < target) send_random_sequence();
   endtask

   initial begin
      req_chan.valid   = 1'b0;
      req_chan.func    = FUNC_NET;
      req_chan.in_byte = 8'd0;
      rsp_chan.ready   = 1'b0;
      csr_we           = 1'b0;
      csr_index        = CSR_TERM_CHARS;
      csr_wdata        = '0;
      tx_idle_pct      = 0;
      rx_idle_pct      = 0;
      hold_request     = 0;
      sent_items       = 0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: "xterm", 132x43
      program_regs(64'h0000_006D_7265_7478, 4'd5, 8'd132, 8'd43);
      send_item(FUNC_START, 8'h00);
      send_item(FUNC_NET, 8'h00);
      send_item(FUNC_NET, 8'h41);
      send_item(FUNC_NET, B_IAC);
      send_item(FUNC_NET, B_IAC);
      send_item(FUNC_NET, B_IAC);
      send_item(FUNC_NET, B_DO);
      send_item(FUNC_NET, OPT_NAWS);
      send_item(FUNC_NET, B_IAC);
      send_item(FUNC_NET, B_SB);
      send_item(FUNC_NET, OPT_TTYPE);
      send_item(FUNC_NET, SUB_SEND);
      send_item(FUNC_NET, B_IAC);
      send_item(FUNC_NET, B_SE);
      send_item(FUNC_NET, B_IAC);
      send_item(FUNC_NET, B_WILL);
      send_item(FUNC_NET, OPT_ECHO);
      send_item(FUNC_APP, B_IAC);        // echo off: doubled only
      send_item(FUNC_NET, B_IAC);
      send_item(FUNC_NET, B_WONT);
      send_item(FUNC_NET, OPT_ECHO);
      send_item(FUNC_APP, 8'h00);        // echo on: zero reaches the parser
      send_item(FUNC_APP, B_IAC);
      send_item(FUNC_NET, 8'hF1);        // unknown command back to data
      send_item(FUNC_NET, B_IAC);
      send_item(FUNC_NET, B_DO);
      send_item(FUNC_NET, OPT_BINARY);
      send_item(FUNC_UNUSED, 8'hFF);
      wait_idle();

      // oversized text length saturates, largest window
      program_regs(64'hFFFF_FFFF_FFFF_FFFF, 4'd15, 8'd255, 8'd255);
      tx_idle_pct = 7;
      rx_idle_pct = 61;
      run_random_phase(PHASE_ITEMS);
      wait_idle();

      // zero characters inside the text, zero window
      program_regs(64'h0041_0000_4200_0043, 4'd8, 8'd0, 8'd0);
      tx_idle_pct = 61;
      rx_idle_pct = 7;
      run_random_phase(PHASE_ITEMS);
      wait_idle();

      program_regs({$urandom, $urandom}, 4'd0, 8'($urandom_range(255)),
                   8'($urandom_range(255)));
      tx_idle_pct = 0;
      rx_idle_pct = 0;
      hold_request++;
      run_random_phase(PHASE_ITEMS);
      wait_idle();

      if (mismatch_count == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

// ===== files.f =====
sv/tcn_pkg.sv
sv/tcn_if.sv
sv/tcn_front.sv
sv/tcn_queue.sv
sv/tcn_back.sv
sv/telnet_client_negotiator_core.sv
sv/tcn_checker.sv
tb/sv/reply_scoreboard.sv
tb/sv/tb.sv
